[hdl/rhp_pkg.sv]
// ============================================================================
// rhp_pkg: shared types and constants for the rainbow HSV pixel core
// Holds the item structs, register map, hue arithmetic constants and the
// pipeline geometry that the core, its divider and its checker rely on.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package rhp_pkg;

    // One input item: which frame and which LED.
    typedef struct packed {
        logic [7:0] frame_index;
        logic [5:0] led_index;
    } t_pixel_in;

    // One result item: the LED's color bytes.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel_out;

    // Register word index on the configuration port (paddr[3:2]).
    typedef enum logic [1:0] {
        REG_FRAME_COUNT = 2'd0,
        REG_HUE_STEP    = 2'd1,
        REG_PEAK_LEVEL  = 2'd2
    } t_reg_idx;

    // HSV sectors of 60 degrees each.
    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } t_sector;

    localparam int unsigned PADDR_W = 4;

    // Register reset values.
    localparam logic [7:0] FRAME_COUNT_RST = 8'd60;
    localparam logic [8:0] HUE_STEP_RST    = 9'd10;
    localparam logic [7:0] PEAK_LEVEL_RST  = 8'd204;

    localparam int unsigned LED_COUNT = 36;

    // Hue is kept in 1/64 degree: full circle 23040 = 45 * 512,
    // one sector 3840 = 15 * 256.
    localparam int unsigned HUE_FULL    = 23040;
    localparam int unsigned HUE_SECTOR  = 3840;
    localparam int unsigned HUE_FRAME_K = 45;   // 23040 >> 9
    localparam int unsigned HUE_LO_W    = 9;

    // Reciprocals for constant division; each is exact over its input range.
    localparam int unsigned RECIP_45    = 23302; // ceil(2^20/45), x < 2^15
    localparam int unsigned RECIP_45_SH = 20;
    localparam int unsigned RECIP_360   = 23302; // ceil(2^23/360), x < 2^15
    localparam int unsigned RECIP_360_SH = 23;
    localparam int unsigned RECIP_15    = 4370;  // ceil(2^16/15), x < 2^12
    localparam int unsigned RECIP_15_SH = 16;

    // Frame divider geometry: 24-bit dividend, 4 quotient bits per stage.
    localparam int unsigned DIV_W      = 24;
    localparam int unsigned DIV_BITS   = 4;
    localparam int unsigned DIV_STAGES = DIV_W / DIV_BITS;

    // Clock edges from the accepting edge to the edge that loads the result.
    localparam int unsigned RHP_LATENCY = DIV_STAGES + 6;

endpackage

`default_nettype wire

[hdl/rhp_div.sv]
// ============================================================================
// rhp_div: pipelined unsigned divider for the frame term of the hue
// Restoring long division of a 24-bit dividend by an 8-bit divisor, four
// quotient bits per register stage. A new item may enter every cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rhp_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic [rhp_pkg::DIV_W-1:0] i_num,
    input  wire logic [7:0]               i_den,
    output logic                          o_valid,
    output logic [rhp_pkg::DIV_W-1:0]     o_quot
);
    import rhp_pkg::*;

    // Four restoring steps: shift a dividend bit into the partial remainder,
    // subtract the divisor when it fits, and shift the quotient bit in.
    function automatic logic [8+DIV_W-1:0] div_step(
        input logic [7:0]       rem,
        input logic [DIV_W-1:0] acc,
        input logic [7:0]       den
    );
        logic [8:0]       t;
        logic [7:0]       r;
        logic [DIV_W-1:0] a;
        r = rem;
        a = acc;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {r, a[DIV_W-1]};
            a = {a[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, den}) begin
                t    = t - {1'b0, den};
                a[0] = 1'b1;
            end
            r = t[7:0];
        end
        return {r, a};
    endfunction

    logic             r_vld [DIV_STAGES];
    logic [7:0]       r_rem [DIV_STAGES];
    logic [DIV_W-1:0] r_acc [DIV_STAGES];

    logic             s_vld [DIV_STAGES+1];
    logic [7:0]       s_rem [DIV_STAGES+1];
    logic [DIV_W-1:0] s_acc [DIV_STAGES+1];

    logic [7:0]       n_rem [DIV_STAGES];
    logic [DIV_W-1:0] n_acc [DIV_STAGES];

    // Stage inputs: the first stage takes the new item, the rest the stage before.
    always_comb begin
        s_vld[0] = i_valid;
        s_rem[0] = 8'd0;
        s_acc[0] = i_num;
        for (int k = 0; k < DIV_STAGES; k++) begin
            s_vld[k+1] = r_vld[k];
            s_rem[k+1] = r_rem[k];
            s_acc[k+1] = r_acc[k];
        end
    end

    // One block of quotient bits per stage.
    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            {n_rem[k], n_acc[k]} = div_step(s_rem[k], s_acc[k], i_den);
        end
    end

    // Valid bits travel with the partial results.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= s_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            r_rem[k] <= n_rem[k];
            r_acc[k] <= n_acc[k];
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_quot  = r_acc[DIV_STAGES-1];

endmodule

`default_nettype wire

[hdl/rainbow_hsv_pixel_core.sv]
// ============================================================================
// rainbow_hsv_pixel_core: rainbow color of one LED for one frame
// Hue in 1/64 degree from the frame and LED position, split into six HSV
// sectors at full saturation, scaled by a programmable peak level.
// ============================================================================
//
// Channel    Direction  Handshake                    Payload
// ---------  ---------  ---------------------------  -------------------------
// item in    input      start, busy                  i_pixel (t_pixel_in)
// item out   output     o_done (one-cycle strobe)    o_color (t_pixel_out)
// config     input      psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// An item is taken in every cycle that start is high; busy stays low.
// Its result shows on o_color for one cycle, once the item has passed the entry
// stage, the 6-stage frame divider, stages 1 to 5 and the output stage.
// Synchronous active-low reset empties the pipeline and loads the register
// defaults. The result side has no back-pressure, so the pipeline never stalls.
//
`timescale 1ns / 1ps
`default_nettype none

module rainbow_hsv_pixel_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire rhp_pkg::t_pixel_in           i_pixel,
    output logic                              o_done,
    output rhp_pkg::t_pixel_out               o_color,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rhp_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import rhp_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] r_frame_count;
    logic [8:0] r_hue_step;
    logic [7:0] r_peak_level;
    logic       cfg_wr;
    t_reg_idx   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    // Register writes on the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_COUNT_RST;
            r_hue_step    <= HUE_STEP_RST;
            r_peak_level  <= PEAK_LEVEL_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FRAME_COUNT: r_frame_count <= pwdata[7:0];
                REG_HUE_STEP:    r_hue_step    <= pwdata[8:0];
                REG_PEAK_LEVEL:  r_peak_level  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (cfg_idx)
            REG_FRAME_COUNT: prdata = {24'd0, r_frame_count};
            REG_HUE_STEP:    prdata = {23'd0, r_hue_step};
            REG_PEAK_LEVEL:  prdata = {24'd0, r_peak_level};
            default:         prdata = 32'd0;
        endcase
    end

    // Every item flows straight through the pipeline.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Entry stage: dividend frame*23040 and the LED offset product
    // ------------------------------------------------------------------
    logic             accept;
    logic             r_a_vld;
    logic [DIV_W-1:0] r_a_num;
    logic [14:0]      r_a_lh;
    logic             r_a_ok;
    logic [13:0]      frame_k;

    assign accept  = start && !busy;
    assign frame_k = 14'({6'd0, i_pixel.frame_index} * 14'(HUE_FRAME_K));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_num <= DIV_W'({frame_k, {HUE_LO_W{1'b0}}});
        r_a_lh  <= 15'({9'd0, i_pixel.led_index} * {6'd0, r_hue_step});
        r_a_ok  <= (i_pixel.led_index < 6'(LED_COUNT));
    end

    // ------------------------------------------------------------------
    // Frame divider, with the LED term delayed alongside
    // ------------------------------------------------------------------
    logic             div_vld;
    logic [DIV_W-1:0] div_quot;
    logic [14:0]      r_sb_lh [DIV_STAGES];
    logic             r_sb_ok [DIV_STAGES];

    rhp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_vld),
        .i_num   (r_a_num),
        .i_den   (r_frame_count),
        .o_valid (div_vld),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        r_sb_lh[0] <= r_a_lh;
        r_sb_ok[0] <= r_a_ok;
        for (int k = 1; k < DIV_STAGES; k++) begin
            r_sb_lh[k] <= r_sb_lh[k-1];
            r_sb_ok[k] <= r_sb_ok[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: reciprocal quotients for mod 45 and mod 360
    // ------------------------------------------------------------------
    logic          r1_vld;
    logic [14:0]   r1_x;
    logic [8:0]    r1_lo;
    logic [7:0]    r1_q45;
    logic [14:0]   r1_lh;
    logic [6:0]    r1_q360;
    logic          r1_ok;
    logic [14:0]   base_x;
    logic [8:0]    base_lo;
    logic [29:0]   mul45;
    logic [29:0]   mul360;

    // A zero frame count makes the frame term zero.
    assign base_x  = (r_frame_count == 8'd0) ? 15'd0 : div_quot[DIV_W-1:HUE_LO_W];
    assign base_lo = (r_frame_count == 8'd0) ? 9'd0  : div_quot[HUE_LO_W-1:0];
    assign mul45   = {15'd0, base_x} * 30'(RECIP_45);
    assign mul360  = {15'd0, r_sb_lh[DIV_STAGES-1]} * 30'(RECIP_360);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_x    <= base_x;
        r1_lo   <= base_lo;
        r1_q45  <= mul45[RECIP_45_SH +: 8];
        r1_lh   <= r_sb_lh[DIV_STAGES-1];
        r1_q360 <= mul360[RECIP_360_SH +: 7];
        r1_ok   <= r_sb_ok[DIV_STAGES-1];
    end

    // ------------------------------------------------------------------
    // Stage 2: remainders give frame term mod 23040 and LED term mod 360
    // ------------------------------------------------------------------
    logic        r2_vld;
    logic [14:0] r2_bmod;
    logic [8:0]  r2_r360;
    logic        r2_ok;
    logic [14:0] rem45;
    logic [14:0] rem360;

    assign rem45  = r1_x - 15'({7'd0, r1_q45} * 15'(HUE_FRAME_K));
    assign rem360 = r1_lh - 15'({8'd0, r1_q360} * 15'd360);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_bmod <= {rem45[5:0], r1_lo};
        r2_r360 <= rem360[8:0];
        r2_ok   <= r1_ok;
    end

    // ------------------------------------------------------------------
    // Stage 3: hue sum wrapped once around the circle
    // ------------------------------------------------------------------
    logic        r3_vld;
    logic [14:0] r3_hue;
    logic        r3_ok;
    logic [15:0] hue_sum;

    assign hue_sum = {1'b0, r2_bmod} + {1'b0, r2_r360, 6'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hue_sum >= 16'(HUE_FULL)) begin
            r3_hue <= 15'(hue_sum - 16'(HUE_FULL));
        end else begin
            r3_hue <= hue_sum[14:0];
        end
        r3_ok <= r2_ok;
    end

    // ------------------------------------------------------------------
    // Stage 4: sector and position within it, mirrored in odd sectors
    // ------------------------------------------------------------------
    logic        r4_vld;
    t_sector     r4_sec;
    logic [11:0] r4_g;
    logic        r4_ok;
    logic [2:0]  sec_num;
    logic [14:0] sec_base;
    logic [11:0] frac;

    assign sec_num = 3'(r3_hue >= 15'(HUE_SECTOR)) + 3'(r3_hue >= 15'(2 * HUE_SECTOR))
                   + 3'(r3_hue >= 15'(3 * HUE_SECTOR)) + 3'(r3_hue >= 15'(4 * HUE_SECTOR))
                   + 3'(r3_hue >= 15'(5 * HUE_SECTOR));
    assign sec_base = 15'({12'd0, sec_num} * 15'(HUE_SECTOR));
    assign frac     = 12'(r3_hue - sec_base);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_sec <= t_sector'(sec_num);
        r4_g   <= sec_num[0] ? 12'(12'(HUE_SECTOR) - frac) : frac;
        r4_ok  <= r3_ok;
    end

    // ------------------------------------------------------------------
    // Stage 5: scale by the peak level
    // ------------------------------------------------------------------
    logic        r5_vld;
    t_sector     r5_sec;
    logic [19:0] r5_prod;
    logic        r5_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_prod <= {12'd0, r_peak_level} * {8'd0, r4_g};
        r5_sec  <= r4_sec;
        r5_ok   <= r4_ok;
    end

    // ------------------------------------------------------------------
    // Output stage: divide by 3840 and place the channels by sector
    // ------------------------------------------------------------------
    logic        r_done;
    t_pixel_out  r_color;
    t_pixel_out  n_color;
    logic [24:0] ramp_mul;
    logic [7:0]  ramp;
    logic [7:0]  pk;

    // (prod >> 8) / 15 through the reciprocal.
    assign ramp_mul = {13'd0, r5_prod[19:8]} * 25'(RECIP_15);
    assign ramp     = ramp_mul[RECIP_15_SH +: 8];
    assign pk       = r_peak_level;

    always_comb begin
        case (r5_sec)
            SEC_RED_YELLOW:   n_color = '{red: pk,   green: ramp, blue: 8'd0};
            SEC_YELLOW_GREEN: n_color = '{red: ramp, green: pk,   blue: 8'd0};
            SEC_GREEN_CYAN:   n_color = '{red: 8'd0, green: pk,   blue: ramp};
            SEC_CYAN_BLUE:    n_color = '{red: 8'd0, green: ramp, blue: pk};
            SEC_BLUE_MAGENTA: n_color = '{red: ramp, green: 8'd0, blue: pk};
            default:          n_color = '{red: pk,   green: 8'd0, blue: ramp};
        endcase
        // An LED past the end of the strip stays dark.
        if (!r5_ok) begin
            n_color = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_color <= n_color;
    end

    assign o_done  = r_done;
    assign o_color = r_color;

endmodule

`default_nettype wire

[hdl/rhp_checker.sv]
// ============================================================================
// rhp_checker: port-level checks for the rainbow HSV pixel core
// Watches item timing and color shape on the top-level ports; bound below.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rhp_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    input  wire logic                         busy,
    input  wire rhp_pkg::t_pixel_in           i_pixel,
    input  wire logic                         o_done,
    input  wire rhp_pkg::t_pixel_out          o_color
);
    import rhp_pkg::*;

    localparam int unsigned SEEN   = RHP_LATENCY + 1;
    localparam int unsigned WARM   = RHP_LATENCY + 2;
    localparam int unsigned WARM_W = $clog2(WARM + 1);

    logic [WARM_W-1:0] r_warm;
    logic              warm;
    logic              acc;

    // Edges since reset, so that past samples never reach back into reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= '0;
        end else if (r_warm != WARM_W'(WARM)) begin
            r_warm <= r_warm + 1'b1;
        end
    end

    assign warm = (r_warm == WARM_W'(WARM));
    assign acc  = start && !busy;

    // Every accepted item yields its result a fixed time later.
    a_item_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        warm && $past(acc, SEEN) |-> o_done)
        else $error("accepted item gave no result on time");

    // No result appears without an item accepted at the matching time.
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        warm && o_done |-> $past(acc, SEEN))
        else $error("result without a matching item");

    // An LED beyond the strip is dark.
    a_dark_beyond_strip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        warm && $past(acc && (i_pixel.led_index >= 6'(LED_COUNT)), SEEN)
        |-> (o_color == '0))
        else $error("LED beyond the strip is lit");

    // Full saturation: at least one channel is zero in every result.
    a_one_channel_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_color.red == 8'd0 || o_color.green == 8'd0
                    || o_color.blue == 8'd0))
        else $error("result has no zero channel");

endmodule

bind rainbow_hsv_pixel_core rhp_checker u_rhp_checker (.*);

`default_nettype wire
